// ===== sv/b2da_pkg.sv =====
// Shared constants and controller/datapath interface types for the binary-to-decimal converter.
package b2da_pkg;

  // Field widths of the input and result words.
  localparam int unsigned ValueW  = 64;
  localparam int unsigned CapW    = 8;
  localparam int unsigned CharW   = 6;
  localparam int unsigned CountW  = 5;

  // Decimal digits needed for the largest 64-bit value.
  localparam int unsigned NumDigits = 20;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned IdxW      = $clog2(NumDigits);
  localparam int unsigned BitCntW   = $clog2(ValueW);

  // Stream widths, padded to whole bytes.
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 16;

  // ASCII code of the digit zero.
  localparam logic [CharW-1:0] AsciiZero = 6'd48;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a new input word
    logic shift;  // one double-dabble step
    logic eval;   // count digits and check the capacity
    logic emit;   // load the next result into the output register
  } b2da_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;  // the current shift step is the last one
    logic emit_last;  // the next result to emit is the final one
    logic out_free;   // the output register can take a result this cycle
  } b2da_status_t;

endpackage

// ===== sv/b2da_ctrl.sv =====
// Controller state machine that sequences conversion, evaluation and digit output.
module b2da_ctrl
  import b2da_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  b2da_status_t status_i,
  output b2da_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEval = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.shift = 1'b1;
        if (status_i.conv_done) begin
          state_d = StEval;
        end
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        state_d    = StEmit;
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.emit_last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/b2da_datapath.sv =====
// Datapath: bit-serial double-dabble converter, digit counter and output word register.
module b2da_datapath
  import b2da_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ValueW-1:0]   value_i,
  input  logic [CapW-1:0]     cap_i,
  input  b2da_cmd_t           cmd_i,
  output b2da_status_t        status_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [CharW-1:0]    digit_char_o,
  output logic                is_last_o,
  output logic                too_small_o,
  output logic [CountW-1:0]   digit_count_o
);

  logic [ValueW-1:0]                 val_q;
  logic [NumDigits-1:0][DigitW-1:0]  bcd_q;
  logic [NumDigits-1:0][DigitW-1:0]  bcd_adj;
  logic [NumDigits*DigitW-1:0]       bcd_flat;
  logic [BitCntW-1:0]                cnt_q;
  logic [CapW-1:0]                   cap_q;
  logic [CountW-1:0]                 len_q, len_d;
  logic                              small_q;
  logic [IdxW-1:0]                   idx_q;
  logic [DigitW-1:0]                 cur_digit;
  logic                              out_valid_q;
  logic [CharW-1:0]                  char_q;
  logic                              last_q, small_out_q;
  logic [CountW-1:0]                 count_q;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[i] = (bcd_q[i] >= DigitW'(5)) ? bcd_q[i] + DigitW'(3) : bcd_q[i];
    end
  end

  // Adjusted digits as one flat vector for the one-bit shift.
  assign bcd_flat = bcd_adj;

  // Digit count: position of the highest nonzero digit, at least one.
  always_comb begin
    len_d = CountW'(1);
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i] != '0) begin
        len_d = CountW'(i + 1);
      end
    end
  end

  assign cur_digit = bcd_q[idx_q];

  // Status back to the controller.
  assign status_o.conv_done = (cnt_q == BitCntW'(ValueW - 1));
  assign status_o.emit_last = small_q || (idx_q == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Conversion and digit bookkeeping registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= value_i;
      cap_q <= cap_i;
      bcd_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.shift) begin
      bcd_q <= {bcd_flat[NumDigits*DigitW-2:0], val_q[ValueW-1]};
      val_q <= {val_q[ValueW-2:0], 1'b0};
      cnt_q <= cnt_q + BitCntW'(1);
    end
    if (cmd_i.eval) begin
      len_q   <= len_d;
      small_q <= (cap_q < (CapW'(len_d) + CapW'(1)));
      idx_q   <= IdxW'(len_d - CountW'(1));
    end
    if (cmd_i.emit) begin
      idx_q <= idx_q - IdxW'(1);
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (small_q) begin
        char_q      <= '0;
        last_q      <= 1'b1;
        small_out_q <= 1'b1;
        count_q     <= '0;
      end else begin
        char_q      <= AsciiZero + CharW'(cur_digit);
        last_q      <= (idx_q == '0);
        small_out_q <= 1'b0;
        count_q     <= len_q;
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digit_char_o  = char_q;
  assign is_last_o     = last_q;
  assign too_small_o   = small_out_q;
  assign digit_count_o = count_q;

endmodule

// ===== sv/binary_to_decimal_ascii.sv =====
// Top level: 64-bit binary to decimal ASCII digit stream converter.
// An accepted word goes through the shift steps of the bit-serial double-dabble loop over the
// 64 input bits and an evaluation step; the results then enter the output register one digit
// per cycle while the output is not stalled by back-pressure, or as a single error result.
// A new word is not accepted until the final result of the last one has entered the output.
// Reset (rst_ni low, asynchronous) returns the controller to idle and empties the output.
module binary_to_decimal_ascii
  import b2da_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // value[63:0], buffer_capacity[71:64]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // digit_char[5:0], digit_count[10:6], zero pad
  output logic                m_axis_tlast_o,
  output logic                m_axis_tuser_o    // too_small[0]
);

  b2da_cmd_t          cmd;
  b2da_status_t       status;
  logic [CharW-1:0]   digit_char;
  logic [CountW-1:0]  digit_count;

  b2da_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  b2da_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (s_axis_tdata_i[ValueW-1:0]),
    .cap_i         (s_axis_tdata_i[ValueW+CapW-1:ValueW]),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .digit_char_o  (digit_char),
    .is_last_o     (m_axis_tlast_o),
    .too_small_o   (m_axis_tuser_o),
    .digit_count_o (digit_count)
  );

  // Pack the result word, digit character in the low bits.
  assign m_axis_tdata_o = {{(OutDataW - CharW - CountW){1'b0}}, digit_count, digit_char};

endmodule

// ===== tb/binary_to_decimal_ascii_tb.sv =====
// Self-checking testbench for the 64-bit binary to decimal ASCII digit stream converter.
module binary_to_decimal_ascii_tb
  import b2da_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected result word on the digit stream.
  typedef struct packed {
    logic [CharW-1:0]  ch;
    logic              last;
    logic              too_small;
    logic [CountW-1:0] count;
  } digit_word_t;

  // One number waiting to be sent, with pacing hints for the driver.
  typedef struct {
    logic [ValueW-1:0] value;
    logic [CapW-1:0]   cap;
    bit                drain;  // wait for every pending digit before sending
    bit                quiet;  // no idle gaps on either side while this is current
  } number_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;   // value[63:0], buffer_capacity[71:64]
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;        // digit_char[5:0], digit_count[10:6], zero pad
  logic                m_axis_tlast_o;
  logic                m_axis_tuser_o;        // too_small[0]

  number_item_t numbers_to_send[$];
  digit_word_t  digits_due[$];
  int           total_numbers;
  int           numbers_sent = 0;
  int           digits_seen = 0;
  int           overflow_words = 0;
  int           longest_text = 0;
  int           mismatches = 0;
  int           send_gap = 0;
  int           recv_gap = 0;
  logic         quiet_mode = 1'b0;
  logic         hold_off = 1'b0;

  binary_to_decimal_ascii dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Free-running clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  // Idle stretch length: mostly none, sometimes short, rarely long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int num_digits(logic [ValueW-1:0] value);
    int n;
    n = 1;
    while (value >= 10) begin
      value = value / 10;
      n++;
    end
    return n;
  endfunction

  function automatic logic [ValueW-1:0] pow10(int k);
    logic [ValueW-1:0] p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  // Work out the digit words one number produces and queue them in order.
  function automatic void predict_text(logic [ValueW-1:0] value, logic [CapW-1:0] cap);
    logic [ValueW-1:0] rest;
    logic [DigitW-1:0] dig [NumDigits];
    digit_word_t       w;
    int                n;
    rest = value;
    n = 0;
    // Split into decimal digits, least significant first.
    while (n == 0 || (rest != 0 && n < NumDigits)) begin
      dig[n] = DigitW'(rest % 10);
      rest = rest / 10;
      n++;
    end
    // A buffer without room for the digits and the terminator gives one error word.
    if (int'(cap) < n + 1) begin
      w.ch = '0;
      w.last = 1'b1;
      w.too_small = 1'b1;
      w.count = '0;
      digits_due.push_back(w);
      return;
    end
    for (int k = 0; k < n; k++) begin
      w.ch = AsciiZero + CharW'(dig[n - 1 - k]);
      w.last = (k == n - 1);
      w.too_small = 1'b0;
      w.count = CountW'(n);
      digits_due.push_back(w);
    end
  endfunction

  task automatic add_number(logic [ValueW-1:0] value, int cap, bit drain = 0, bit quiet = 0);
    number_item_t it;
    it.value = value;
    it.cap = CapW'(cap);
    it.drain = drain;
    it.quiet = quiet;
    numbers_to_send.push_back(it);
  endtask

  // Driver: offers numbers from the queue, with random gaps and optional drain pauses.
  always @(posedge clk_i or negedge rst_ni) begin
    logic         busy;
    number_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= '0;
    end else begin
      busy = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_text(s_axis_tdata_i[ValueW-1:0], s_axis_tdata_i[ValueW+CapW-1:ValueW]);
        numbers_sent++;
        busy = 1'b0;
        send_gap = idle_len();
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (numbers_to_send.size() > 0 &&
                     !(numbers_to_send[0].drain && digits_due.size() != 0)) begin
          it = numbers_to_send.pop_front();
          s_axis_tdata_i <= {it.cap, it.value};
          quiet_mode <= it.quiet;
          busy = 1'b1;
        end
      end
      s_axis_tvalid_i <= busy;
    end
  end

  // Monitor: takes digit words with random back-pressure and checks each one.
  always @(posedge clk_i or negedge rst_ni) begin
    digit_word_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        digits_seen++;
        if (m_axis_tuser_o) overflow_words++;
        if (digits_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word data=%h last=%b user=%b",
                                    m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o));
        end else begin
          want = digits_due.pop_front();
          if (m_axis_tdata_o[CharW-1:0] !== want.ch)
            report_mismatch($sformatf("digit_char expected %0d, got %0d",
                                      want.ch, m_axis_tdata_o[CharW-1:0]));
          if (m_axis_tdata_o[CharW+CountW-1:CharW] !== want.count)
            report_mismatch($sformatf("digit_count expected %0d, got %0d",
                                      want.count, m_axis_tdata_o[CharW+CountW-1:CharW]));
          if (m_axis_tlast_o !== want.last)
            report_mismatch($sformatf("is_last expected %b, got %b",
                                      want.last, m_axis_tlast_o));
          if (m_axis_tuser_o !== want.too_small)
            report_mismatch($sformatf("too_small expected %b, got %b",
                                      want.too_small, m_axis_tuser_o));
          if (int'(want.count) > longest_text) longest_text = int'(want.count);
        end
      end
      // Back-pressure: forced hold-off first, then random stalls.
      if (hold_off) begin
        m_axis_tready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        recv_gap = idle_len();
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering, so the input stalls.
  initial begin
    wait (digits_seen >= 200);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Timeout guard.
  initial begin
    #30_000_000;
    $display("Timed out with %0d of %0d numbers sent, %0d words pending",
             numbers_sent, total_numbers, digits_due.size());
    $display("FAIL");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [ValueW-1:0] v;
    int                r;
    int                nd;
    int                cap;

    // Directed: zero, capacity limits, decade boundaries and the largest value.
    add_number(64'd0, 255);
    add_number(64'd0, 0);
    add_number(64'd0, 1);
    add_number(64'd0, 2);
    add_number(64'd1, 255);
    add_number(64'd9, 2);
    add_number(64'd10, 2);
    add_number(64'd10, 3);
    add_number(64'd99, 3);
    add_number(64'd100, 4);
    add_number(64'd1234567890, 11);
    add_number(64'd1234567890, 10);
    add_number(pow10(19) - 1, 20);
    add_number(pow10(19) - 1, 19);
    add_number(pow10(19), 21);
    add_number(pow10(19), 20);
    add_number({ValueW{1'b1}}, 20);
    add_number({ValueW{1'b1}}, 21);
    add_number({ValueW{1'b1}}, 255);
    add_number({ValueW{1'b1}}, 0);
    add_number({32{2'b01}}, 8'hAA);
    add_number({32{2'b10}}, 8'h55);
    add_number(64'h8000_0000_0000_0000, 128);
    add_number(64'd7, 127);

    // Random: mixed magnitudes, capacities mostly near the needed size.
    for (int i = 0; i < 356; i++) begin
      r = $urandom_range(0, 9);
      if (r < 4) v = {$urandom, $urandom};
      else if (r < 8) v = {$urandom, $urandom} >> $urandom_range(0, 63);
      else v = pow10($urandom_range(0, 19)) - $urandom_range(0, 1);
      nd = num_digits(v);
      r = $urandom_range(0, 9);
      if (r < 5) cap = nd - 1 + $urandom_range(0, 3);
      else if (r < 8) cap = $urandom_range(0, 255);
      else cap = 255;
      add_number(v, cap, i == 0 || i % 60 == 59, i >= 120 && i < 170);
    end
    total_numbers = numbers_to_send.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (numbers_sent < total_numbers || digits_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Converted %0d numbers into %0d words, %0d of them buffer-overflow errors.",
             numbers_sent, digits_seen, overflow_words);
    $display("Longest text was %0d digits; %0d mismatches.", longest_text, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
